// ===== src/ssp_pkg.sv =====
package ssp_pkg;

  localparam int BAND_W        = 5;
  localparam int MAG_W         = 16;
  localparam int SCF_W         = 32;
  localparam int FRAC_W        = SCF_W - 1;
  localparam int POS_W         = 5;
  localparam int ROM_W         = 16;
  localparam int MAX_BINS      = 8;
  localparam int BINS_PER_BAND = 8;
  localparam int ACC_W         = 34;

  localparam logic signed [ACC_W-1:0] DB_PER_OCTAVE_Q24 = 34'sd101008905;
  localparam logic signed [ACC_W-1:0] TEN_DB_Q24        = 34'sd167772160;
  localparam logic signed [ACC_W-1:0] ROUND_HALF        = 34'sd32768;
  localparam logic signed [POS_W:0]   SCF_EXP_OFFSET    = 6'sd15;
  localparam logic signed [MAG_W-1:0] LEVEL_MIN         = 16'sh8000;

  typedef logic [BAND_W-1:0]         band_t;
  typedef logic signed [MAG_W-1:0]   mag_t;
  typedef logic [MAG_W-1:0]          mag_bits_t;
  typedef mag_bits_t [MAX_BINS-1:0]  mag_vec_t;
  typedef logic [SCF_W-1:0]          scf_t;
  typedef logic [FRAC_W-1:0]         frac_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [ROM_W-1:0]          rom_word_t;

  typedef struct packed {
    pos_t  pos;
    logic  zero;
    frac_t frac;
  } norm_t;

  // 20*log10 of a mantissa in Q1.30, [1,2), as unsigned Q4.12; elaboration only
  function automatic rom_word_t frac_db_q12(logic [63:0] mant);
    logic [63:0] m;
    logic [63:0] res;
    logic [63:0] q;
    m   = mant;
    res = '0;
    for (int b = 23; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m      = m >> 1;
        res[b] = 1'b1;
      end
    end
    q = (res * 64'd101008905 + (64'd1 << 35)) >> 36;
    return q[ROM_W-1:0];
  endfunction

endpackage

// ===== src/ssp_peak.sv =====
module ssp_peak (
  input  ssp_pkg::mag_vec_t mag_i,
  output ssp_pkg::mag_t     peak_o
);

  // search starts from 0 dB
  always_comb begin
    peak_o = '0;
    for (int k = 0; k < ssp_pkg::BINS_PER_BAND; k++) begin
      if ($signed(mag_i[k]) > peak_o) begin
        peak_o = $signed(mag_i[k]);
      end
    end
  end

endmodule

// ===== src/ssp_norm.sv =====
module ssp_norm (
  input  logic          clk,
  input  ssp_pkg::scf_t scf_i,
  output ssp_pkg::norm_t norm_o
);

  ssp_pkg::pos_t  pos_nxt;
  ssp_pkg::pos_t  pos_r;
  ssp_pkg::scf_t  scf_r;
  logic           zero_r;
  ssp_pkg::scf_t  shifted;
  ssp_pkg::norm_t norm_r;

  // leading-one position
  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < ssp_pkg::SCF_W; b++) begin
      if (scf_i[b]) begin
        pos_nxt = ssp_pkg::POS_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    scf_r  <= scf_i;
    zero_r <= (scf_i == '0);
  end

  // move the leading one to the top bit, keep the bits below it
  assign shifted = scf_r << (ssp_pkg::POS_W'(ssp_pkg::SCF_W - 1) - pos_r);

  always_ff @(posedge clk) begin
    norm_r.pos  <= pos_r;
    norm_r.zero <= zero_r;
    norm_r.frac <= shifted[ssp_pkg::FRAC_W-1:0];
  end

  assign norm_o = norm_r;

endmodule

// ===== src/ssp_log_rom.sv =====
module ssp_log_rom #(
  parameter int LOG_TABLE_ENTRIES = 1000
) (
  input  logic               clk,
  input  ssp_pkg::frac_t     frac_i,
  output ssp_pkg::rom_word_t rdata_o
);

  localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int PROD_W = ssp_pkg::FRAC_W + CNT_W;

  typedef ssp_pkg::rom_word_t rom_t [LOG_TABLE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] mant;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      mant   = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      tbl[i] = ssp_pkg::frac_db_q12(mant);
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [PROD_W-1:0]  prod;
  logic [IDX_W-1:0]   idx;
  ssp_pkg::rom_word_t rdata_r;

  // index = frac * entries / 2^31, always below the entry count
  assign prod = {{CNT_W{1'b0}}, frac_i} * PROD_W'(LOG_TABLE_ENTRIES);
  assign idx  = prod[ssp_pkg::FRAC_W+IDX_W-1:ssp_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    rdata_r <= ROM[idx];
  end

  assign rdata_o = rdata_r;

endmodule

// ===== src/subband_sound_pressure_level.sv =====
// channel   ports                                              handshake
// --------  -------------------------------------------------  ------------------------
// input     in_band_number, in_mag_0..in_mag_7, in_scalefactor  start && !busy
// result    out_level_band_number, out_sound_level_db          out_valid, one cycle
//
// one request per clock while busy is low; the result strobe goes high after the
// input register, leading-one detect, normalize, log rom read and level combine stages.
// busy is set by reset and drops at the first edge that samples rst_n high; the log
// rom is a constant table, so no clearing pass follows reset. synchronous active-low
// reset clears the valid pipeline. the receiver cannot stall: each result shows for
// exactly one cycle.
module subband_sound_pressure_level #(
  parameter int LOG_TABLE_ENTRIES = 1000
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ssp_pkg::band_t      in_band_number,
  input  ssp_pkg::mag_t       in_mag_0,
  input  ssp_pkg::mag_t       in_mag_1,
  input  ssp_pkg::mag_t       in_mag_2,
  input  ssp_pkg::mag_t       in_mag_3,
  input  ssp_pkg::mag_t       in_mag_4,
  input  ssp_pkg::mag_t       in_mag_5,
  input  ssp_pkg::mag_t       in_mag_6,
  input  ssp_pkg::mag_t       in_mag_7,
  input  ssp_pkg::scf_t       in_scalefactor,
  output logic                out_valid,
  output ssp_pkg::band_t      out_level_band_number,
  output ssp_pkg::mag_t       out_sound_level_db
);

  logic               busy_r;
  logic               accept;
  logic [4:0]         vld_r;

  ssp_pkg::band_t     band1_r, band2_r, band3_r, band4_r, band5_r;
  ssp_pkg::mag_vec_t  mag1_r;
  ssp_pkg::scf_t      scf1_r;
  ssp_pkg::mag_t      peak;
  ssp_pkg::mag_t      xmax2_r, xmax3_r, xmax4_r;
  ssp_pkg::norm_t     norm3;
  ssp_pkg::pos_t      pos4_r;
  logic               zero4_r;
  ssp_pkg::rom_word_t rom4;

  logic signed [ssp_pkg::POS_W:0]   octave;
  logic signed [ssp_pkg::ACC_W-1:0] acc;
  logic signed [ssp_pkg::ACC_W-1:0] rnd;
  ssp_pkg::mag_t                    level;
  ssp_pkg::mag_t                    result_nxt;
  ssp_pkg::mag_t                    level5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[3:0], accept};
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      band1_r   <= in_band_number;
      mag1_r[0] <= in_mag_0;
      mag1_r[1] <= in_mag_1;
      mag1_r[2] <= in_mag_2;
      mag1_r[3] <= in_mag_3;
      mag1_r[4] <= in_mag_4;
      mag1_r[5] <= in_mag_5;
      mag1_r[6] <= in_mag_6;
      mag1_r[7] <= in_mag_7;
      scf1_r    <= in_scalefactor;
    end
  end

  ssp_peak u_peak (
    .mag_i  (mag1_r),
    .peak_o (peak)
  );

  ssp_norm u_norm (
    .clk    (clk),
    .scf_i  (scf1_r),
    .norm_o (norm3)
  );

  ssp_log_rom #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
  ) u_log_rom (
    .clk     (clk),
    .frac_i  (norm3.frac),
    .rdata_o (rom4)
  );

  always_ff @(posedge clk) begin
    band2_r  <= band1_r;
    xmax2_r  <= peak;
    band3_r  <= band2_r;
    xmax3_r  <= xmax2_r;
    band4_r  <= band3_r;
    xmax4_r  <= xmax3_r;
    pos4_r   <= norm3.pos;
    zero4_r  <= norm3.zero;
    band5_r  <= band4_r;
    level5_r <= result_nxt;
  end

  // octave count in q.24 dB plus the rom fraction, minus 10 dB, rounded half up
  always_comb begin
    octave = $signed({1'b0, pos4_r}) - ssp_pkg::SCF_EXP_OFFSET;
    acc    = ssp_pkg::ACC_W'(octave * ssp_pkg::DB_PER_OCTAVE_Q24)
           + $signed({6'b0, rom4, 12'b0})
           - ssp_pkg::TEN_DB_Q24;
    rnd    = acc + ssp_pkg::ROUND_HALF;
    level  = zero4_r ? ssp_pkg::LEVEL_MIN : $signed(rnd[31:16]);
    result_nxt = (xmax4_r > level) ? xmax4_r : level;
  end

  assign out_valid             = vld_r[4];
  assign out_level_band_number = band5_r;
  assign out_sound_level_db    = level5_r;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ssp_pkg::*;

  localparam int LOG_ENTRIES = 1000;
  localparam int RANDOM_PER_PHASE = 434;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 100;
  localparam logic signed [63:0] OCTAVE_Q24 = 64'sd101008905;
  localparam logic signed [63:0] TEN_DB_Q24 = 64'sd167772160;
  localparam int NUM_ROWS = 18;

  typedef struct packed {
    band_t    band;
    mag_vec_t mag;
    scf_t     scf;
  } band_req_t;

  typedef struct packed {
    band_t band;
    mag_t  level;
  } level_result_t;

  typedef struct packed {
    logic      has_level;
    mag_t      level;
    band_req_t req;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{1'b1, 16'sh0000, '{5'd0, {8{16'h8000}}, 32'h0000_0000}},
    '{1'b1, 16'sh7fff, '{5'd31, {8{16'h7fff}}, 32'h0000_0000}},
    '{1'b1, 16'sh1234, '{5'd5, {16'h1234, 16'h0fff, 16'h8001, 16'h0001,
                                16'hff00, 16'h1000, 16'h0000, 16'h1233}, 32'h0000_0000}},
    '{1'b1, 16'sh0000, '{5'd1, {8{16'h0000}}, 32'h0000_0000}},
    '{1'b1, 16'sh504f, '{5'd2, {8{16'h8000}}, 32'h4000_0000}},
    '{1'b1, 16'sh504f, '{5'd3, {16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h504f, 16'h0000, 16'h0000, 16'h0000}, 32'h4000_0000}},
    '{1'b1, 16'sh5050, '{5'd7, {16'h0000, 16'h5050, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000}, 32'h4000_0000}},
    '{1'b1, 16'sh504f, '{5'd8, {16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'h0000, 16'h504e}, 32'h4000_0000}},
    '{1'b1, 16'sh7fff, '{5'd9, {8{16'h7fff}}, 32'hffff_ffff}},
    '{1'b0, 16'sh0000, '{5'd4, {8{16'h8000}}, 32'hffff_ffff}},
    '{1'b0, 16'sh0000, '{5'd6, {8{16'h8000}}, 32'h8000_0000}},
    '{1'b0, 16'sh0000, '{5'd10, {8{16'h8000}}, 32'h0000_0001}},
    '{1'b0, 16'sh0000, '{5'd11, {8{16'h8000}}, 32'h0000_8000}},
    '{1'b0, 16'sh0000, '{5'd12, {16'h0100, 16'hf000, 16'h0200, 16'h8000,
                                 16'h0010, 16'h7000, 16'h0000, 16'hffff}, 32'h7fff_ffff}},
    '{1'b0, 16'sh0000, '{5'd13, {8{16'hffff}}, 32'h6000_0000}},
    '{1'b0, 16'sh0000, '{5'd14, {8{16'h0001}}, 32'h4000_0001}},
    '{1'b0, 16'sh0000, '{5'd17, {8{16'hffff}}, 32'h0000_0003}},
    '{1'b0, 16'sh0000, '{5'd21, {8{16'h0001}}, 32'hc000_0000}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  band_t out_level_band_number;
  mag_t out_sound_level_db;

  band_req_t cur_req = '0;
  logic row_has_level = 1'b0;
  mag_t row_level = '0;

  rom_word_t db_frac_table [LOG_ENTRIES];
  level_result_t pending_levels [$];
  int fail_count = 0;
  int stall_cycles = 0;

  subband_sound_pressure_level #(
    .LOG_TABLE_ENTRIES(LOG_ENTRIES)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_band_number       (cur_req.band),
    .in_mag_0             (cur_req.mag[0]),
    .in_mag_1             (cur_req.mag[1]),
    .in_mag_2             (cur_req.mag[2]),
    .in_mag_3             (cur_req.mag[3]),
    .in_mag_4             (cur_req.mag[4]),
    .in_mag_5             (cur_req.mag[5]),
    .in_mag_6             (cur_req.mag[6]),
    .in_mag_7             (cur_req.mag[7]),
    .in_scalefactor       (cur_req.scf),
    .out_valid            (out_valid),
    .out_level_band_number(out_level_band_number),
    .out_sound_level_db   (out_sound_level_db)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // 20*log10(1 + i/LOG_ENTRIES) in unsigned Q4.12, via bitwise log2 by squaring
  function automatic rom_word_t frac_db_entry(int unsigned i);
    logic [63:0] mant;
    logic [63:0] log2_q24;
    logic [63:0] db_q12;
    mant = (64'd1 << 30) + ((64'(i) << 30) / 64'(LOG_ENTRIES));
    log2_q24 = '0;
    for (int n = 0; n < 24; n++) begin
      mant = (mant * mant) >> 30;
      log2_q24 = log2_q24 << 1;
      if (mant[31]) begin
        mant = mant >> 1;
        log2_q24[0] = 1'b1;
      end
    end
    db_q12 = (log2_q24 * 64'd101008905 + (64'd1 << 35)) >> 36;
    return db_q12[15:0];
  endfunction

  function automatic mag_t predict_level(band_req_t r);
    logic signed [63:0] peak;
    logic signed [63:0] bin_db;
    logic signed [63:0] scf_db;
    logic signed [63:0] acc;
    logic signed [63:0] octave;
    logic [63:0] frac;
    int pos;
    int idx;
    peak = 0;
    for (int k = 0; k < BINS_PER_BAND; k++) begin
      bin_db = mag_t'(r.mag[k]);
      if (bin_db > peak) peak = bin_db;
    end
    if (r.scf == '0) begin
      scf_db = -64'sd32768;
    end else begin
      pos = 31;
      while (!r.scf[pos]) pos--;
      frac = 64'(r.scf ^ (scf_t'(1) << pos)) << (31 - pos);
      idx = int'((frac * 64'(LOG_ENTRIES)) >> 31);
      if (idx >= LOG_ENTRIES) idx = LOG_ENTRIES - 1;
      octave = pos - 15;
      acc = octave * OCTAVE_Q24 + signed'({36'd0, db_frac_table[idx], 12'd0}) - TEN_DB_Q24;
      scf_db = (acc + 64'sd32768) >>> 16;
      if (scf_db < -64'sd32768) scf_db = -64'sd32768;
      if (scf_db > 64'sd32767) scf_db = 64'sd32767;
    end
    if (peak > scf_db) scf_db = peak;
    return scf_db[15:0];
  endfunction

  function automatic band_req_t random_request();
    band_req_t r;
    band_req_t probe;
    mag_t tie_level;
    int unsigned pick;
    r.band = band_t'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    if (pick == 0) r.scf = '0;
    else if (pick == 1) r.scf = scf_t'(1) << $urandom_range(0, 31);
    else if (pick < 5) r.scf = $urandom;
    else r.scf = $urandom >> $urandom_range(0, 31);
    pick = $urandom_range(0, 9);
    for (int k = 0; k < MAX_BINS; k++) begin
      if (pick < 3) r.mag[k] = mag_bits_t'($urandom);
      else if (pick < 6) r.mag[k] = mag_bits_t'($urandom_range(0, 24575) - 12288);
      else r.mag[k] = 16'h8000 | mag_bits_t'($urandom_range(0, 16'h7fff));
    end
    // near tie between the bin peak and the scalefactor level
    if (pick >= 8) begin
      probe = r;
      probe.mag = {MAX_BINS{16'h8000}};
      tie_level = predict_level(probe);
      r.mag = probe.mag;
      r.mag[$urandom_range(0, MAX_BINS - 1)] =
        mag_bits_t'(int'(tie_level) + int'($urandom_range(0, 2)) - 1);
    end
    return r;
  endfunction

  task automatic issue_request(input band_req_t r, input logic has_level, input mag_t level);
    cur_req <= r;
    row_has_level <= has_level;
    row_level <= level;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic maybe_idle(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    level_result_t want;
    if (out_valid === 1'b1) begin
      if (pending_levels.size() == 0) begin
        fail_count++;
        $error("out_sound_level_db: expected no request, got %0d", out_sound_level_db);
      end else begin
        want = pending_levels.pop_front();
        if (out_level_band_number !== want.band) begin
          fail_count++;
          $error("out_level_band_number: expected %0d, got %0d",
                 want.band, out_level_band_number);
        end
        if (out_sound_level_db !== want.level) begin
          fail_count++;
          $error("out_sound_level_db: expected %0d, got %0d", want.level, out_sound_level_db);
        end
      end
    end
    if (start && !busy) begin
      want.band = cur_req.band;
      want.level = row_has_level ? row_level : predict_level(cur_req);
      pending_levels.push_back(want);
    end
    if ((start && !busy) || out_valid === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    int idle_pct [3];
    idle_pct = '{19, 56, 0};
    for (int i = 0; i < LOG_ENTRIES; i++) db_frac_table[i] = frac_db_entry(i);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      maybe_idle(idle_pct[0]);
      issue_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].has_level,
                    DIRECTED_ROWS[i].level);
    end
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        maybe_idle(idle_pct[ph]);
        issue_request(random_request(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
